[src/tfic_pkg.sv]
// shared types and constants of the triangle filter and index compactor
// depends on nothing; every other file but tfic_ram refers to it by scoped names
package tfic_pkg;

    localparam int INDEX_W      = 16;
    localparam int VERTEX_SPACE = 2 ** INDEX_W;
    localparam int MAX_VERTICES = 65536;
    localparam int COMPACT_W    = INDEX_W + 1;
    localparam int EPOCH_W      = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_INVALID = {EPOCH_W{1'b1}};
    localparam logic [EPOCH_W-1:0] EPOCH_LAST    = EPOCH_INVALID - EPOCH_W'(1);
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = QPTR_W + 1;
    localparam int M_DATA_W     = 5 * INDEX_W;

    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_STRIP_MODE    = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EVEN_REVERSED = 1'd1;

    localparam logic KIND_MAP = 1'b0;
    localparam logic KIND_TRI = 1'b1;

    typedef logic [INDEX_W-1:0] index_t;

    // one triangle (or bare stream end) handed from front to back
    typedef struct packed {
        logic                keep;
        logic                swap;
        logic                stream_end;
        logic [2:0][INDEX_W-1:0] corner;
    } job_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

    // remap memory word: epoch mark says whether compact is live this stream
    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        index_t             compact;
    } remap_word_t;

    localparam int REMAP_W = $bits(remap_word_t);

endpackage

[src/triangle_filter_index_compactor.sv]
// top level of the triangle filter and vertex index compactor
// depends on tfic_pkg, tfic_front, tfic_queue, tfic_back (and tfic_ram below it)
//
// Takes a mesh index stream, one vertex index per request with a visibility
// flag, reads it as a triangle strip or a triangle list, drops strip triangles
// with repeated corners and triangles with no visible corner, and for each kept
// triangle reports a mapping request for every corner that gets a new dense
// index, then the triangle with remapped corners (last two corners swapped on
// alternate strip triangles). The front end takes one index per cycle while
// the queue has room and no sweep runs, and forms triangles; a four-entry
// queue feeds the back end, which looks each corner up in turn in a
// 65536-entry remap ram with one write and one read port, and sends the
// triangle from a further state when its third corner is new, since the
// result port carries one request per cycle; a triangle taken up from the
// idle state (back end empty, or the job before it ended a stream) leaves the
// queue there before its lookups start. An index that forms no kept triangle
// is not pushed to the back end unless it ends a stream. The back end holds
// while a result waits on m_tready. The map is cleared per stream by an
// 8-bit epoch mark kept with each entry; after reset, and after every 255th
// stream end, the back end sweeps all 65536 remap ram entries, with s_tready
// low (configuration writes are still taken). The user makes configuration
// changes only while the block is idle; the block does not enforce this.
module triangle_filter_index_compactor (
    input  logic        aclk,
    input  logic        aresetn,

    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tfic_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic                                 cfg_data,

    // input index stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] vertex_index
    input  logic [0:0]  s_tuser,   // [0] visible
    input  logic        s_tlast,   // stream_end

    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [tfic_pkg::M_DATA_W-1:0] m_tdata, // [15:0] original_vertex,
                                                   // [31:16] compact_vertex,
                                                   // [47:32] corner_first,
                                                   // [63:48] corner_second,
                                                   // [79:64] corner_third
    output logic [0:0]  m_tuser,   // [0] kind
    output logic        m_tlast    // run_last
);

    // configuration registers
    logic strip_mode_reg;
    logic even_reversed_reg;

    // front to queue to back
    logic                    push, pop;
    tfic_pkg::job_t          push_job, head_job;
    tfic_pkg::queue_status_t q_status;
    tfic_pkg::back_status_t  b_status;
    logic                    m_kind;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strip_mode_reg    <= 1'b1;
            even_reversed_reg <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                tfic_pkg::CFG_STRIP_MODE:    strip_mode_reg    <= cfg_data;
                tfic_pkg::CFG_EVEN_REVERSED: even_reversed_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // window, triangle forming and filtering
    tfic_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .strip_mode   (strip_mode_reg),
        .even_reversed(even_reversed_reg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .vertex_index (s_tdata),
        .visible      (s_tuser[0]),
        .stream_end   (s_tlast),
        .q_status     (q_status),
        .b_status     (b_status),
        .push         (push),
        .job          (push_job)
    );

    // decouples triangle forming from remap lookups
    tfic_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_job(push_job),
        .pop     (pop),
        .head_job(head_job),
        .status  (q_status)
    );

    // remap lookups, index assignment, result register
    tfic_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head_job(head_job),
        .q_status(q_status),
        .pop     (pop),
        .status  (b_status),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_kind  (m_kind),
        .m_data  (m_tdata),
        .m_last  (m_tlast)
    );

    assign m_tuser[0] = m_kind;

endmodule

[src/tfic_ram.sv]
// generic simple dual port ram: one write port, one registered read port
// no dependencies
module tfic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[src/tfic_front.sv]
// front end: strip/list window, triangle forming, visibility and repeat filter
// depends on tfic_pkg
module tfic_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   strip_mode,
    input  logic                   even_reversed,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  tfic_pkg::index_t       vertex_index,
    input  logic                   visible,
    input  logic                   stream_end,
    input  tfic_pkg::queue_status_t q_status,
    input  tfic_pkg::back_status_t  b_status,
    output logic                   push,
    output tfic_pkg::job_t          job
);

    tfic_pkg::index_t win_idx_reg [2];
    tfic_pkg::index_t win_idx_next [2];
    logic [1:0] win_vis_reg, win_vis_next;
    logic [1:0] pos_reg, pos_next;
    logic       parity_reg, parity_next;

    logic accept, formed, dup, in_range;

    assign in_ready = !q_status.full && !b_status.clearing;
    assign accept   = in_valid && in_ready;
    assign formed   = pos_reg[1];

    always_comb begin
        win_idx_next = win_idx_reg;
        win_vis_next = win_vis_reg;
        pos_next     = pos_reg;
        parity_next  = parity_reg;

        job.corner[0]  = win_idx_reg[0];
        job.corner[1]  = win_idx_reg[1];
        job.corner[2]  = vertex_index;
        job.stream_end = stream_end;
        job.swap       = 1'b0;

        dup = (win_idx_reg[0] == win_idx_reg[1]) || (win_idx_reg[1] == vertex_index)
              || (win_idx_reg[0] == vertex_index);
        in_range = (32'(win_idx_reg[0]) < tfic_pkg::MAX_VERTICES)
                   && (32'(win_idx_reg[1]) < tfic_pkg::MAX_VERTICES)
                   && (32'(vertex_index) < tfic_pkg::MAX_VERTICES);

        job.keep = formed && (win_vis_reg[0] || win_vis_reg[1] || visible)
                   && !(strip_mode && dup) && in_range;

        if (formed) begin
            if (strip_mode) begin
                job.swap        = parity_reg ? !even_reversed : even_reversed;
                parity_next     = !parity_reg;
                win_idx_next[0] = win_idx_reg[1];
                win_vis_next[0] = win_vis_reg[1];
                win_idx_next[1] = vertex_index;
                win_vis_next[1] = visible;
            end else begin
                pos_next = 2'd0;
            end
        end else begin
            win_idx_next[pos_reg[0]] = vertex_index;
            win_vis_next[pos_reg[0]] = visible;
            pos_next                 = pos_reg + 2'd1;
        end

        // stream end: window and parity start over after this item
        if (stream_end) begin
            win_idx_next[0] = '0;
            win_idx_next[1] = '0;
            win_vis_next    = '0;
            pos_next        = 2'd0;
            parity_next     = 1'b0;
        end
    end

    assign push = accept && (job.keep || stream_end);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_idx_reg[0] <= '0;
            win_idx_reg[1] <= '0;
            win_vis_reg    <= '0;
            pos_reg        <= 2'd0;
            parity_reg     <= 1'b0;
        end else if (accept) begin
            win_idx_reg <= win_idx_next;
            win_vis_reg <= win_vis_next;
            pos_reg     <= pos_next;
            parity_reg  <= parity_next;
        end
    end

endmodule

[src/tfic_queue.sv]
// small job queue between front and back
// depends on tfic_pkg
module tfic_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  tfic_pkg::job_t          push_job,
    input  logic                    pop,
    output tfic_pkg::job_t          head_job,
    output tfic_pkg::queue_status_t status
);

    tfic_pkg::job_t entry_reg [tfic_pkg::QUEUE_DEPTH];
    logic [tfic_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [tfic_pkg::QCNT_W-1:0] count_reg, count_next;

    assign head_job     = entry_reg[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == tfic_pkg::QCNT_W'(tfic_pkg::QUEUE_DEPTH));

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + tfic_pkg::QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - tfic_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + tfic_pkg::QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + tfic_pkg::QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

[src/tfic_back.sv]
// back end: remap lookups and assignments through the remap ram, result output
// depends on tfic_pkg and tfic_ram
module tfic_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  tfic_pkg::job_t          head_job,
    input  tfic_pkg::queue_status_t q_status,
    output logic                    pop,
    output tfic_pkg::back_status_t  status,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_kind,
    output logic [tfic_pkg::M_DATA_W-1:0] m_data,
    output logic                    m_last
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_D0    = 3'd2;
    localparam logic [2:0] ST_D1    = 3'd3;
    localparam logic [2:0] ST_D2    = 3'd4;
    localparam logic [2:0] ST_TRI   = 3'd5;

    function automatic logic [tfic_pkg::M_DATA_W-1:0] tri_data(
        input tfic_pkg::index_t m0,
        input tfic_pkg::index_t m1,
        input tfic_pkg::index_t m2,
        input logic             swap
    );
        tri_data = swap ? {m1, m2, m0, 32'd0} : {m2, m1, m0, 32'd0};
    endfunction

    logic [2:0] state_reg, state_next;
    tfic_pkg::job_t job_reg, job_next;
    tfic_pkg::index_t mapped0_reg, mapped0_next, mapped1_reg, mapped1_next;
    tfic_pkg::index_t mapped2_reg, mapped2_next;
    logic [tfic_pkg::EPOCH_W-1:0]   epoch_reg, epoch_next;
    logic [tfic_pkg::COMPACT_W-1:0] next_compact_reg, next_compact_next;
    tfic_pkg::index_t clear_addr_reg, clear_addr_next;
    logic             byp_valid_reg, byp_valid_next;
    tfic_pkg::index_t byp_addr_reg, byp_addr_next;
    tfic_pkg::remap_word_t byp_word_reg, byp_word_next;

    logic m_valid_reg, m_kind_reg, m_last_reg;
    logic [tfic_pkg::M_DATA_W-1:0] m_data_reg;

    logic ram_we, ram_re;
    tfic_pkg::index_t ram_waddr, ram_raddr;
    logic [tfic_pkg::REMAP_W-1:0] ram_wdata, ram_rdata;

    tfic_pkg::index_t      cur_corner, new_compact, mapped_cur;
    tfic_pkg::remap_word_t word_sel, new_word;
    logic hit, out_free, job_done, do_end, take_head;
    logic emit, emit_kind, emit_last;
    logic [tfic_pkg::M_DATA_W-1:0] emit_data;

    tfic_ram #(
        .WIDTH(tfic_pkg::REMAP_W),
        .DEPTH(tfic_pkg::VERTEX_SPACE)
    ) u_remap_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign out_free        = !m_valid_reg || m_ready;
    assign status.clearing = (state_reg == ST_CLEAR);
    assign new_compact     = next_compact_reg[tfic_pkg::INDEX_W-1:0];
    assign new_word        = '{epoch: epoch_reg, compact: new_compact};

    always_comb begin
        case (state_reg)
            ST_D1:   cur_corner = job_reg.corner[1];
            ST_D2:   cur_corner = job_reg.corner[2];
            default: cur_corner = job_reg.corner[0];
        endcase
        // the last write, held in the bypass register, wins over the registered ram word
        if (byp_valid_reg && (byp_addr_reg == cur_corner)) begin
            word_sel = byp_word_reg;
        end else begin
            word_sel = tfic_pkg::remap_word_t'(ram_rdata);
        end
        hit        = (word_sel.epoch == epoch_reg);
        mapped_cur = hit ? word_sel.compact : new_compact;
    end

    always_comb begin
        state_next        = state_reg;
        job_next          = job_reg;
        mapped0_next      = mapped0_reg;
        mapped1_next      = mapped1_reg;
        mapped2_next      = mapped2_reg;
        epoch_next        = epoch_reg;
        next_compact_next = next_compact_reg;
        clear_addr_next   = clear_addr_reg;
        byp_valid_next    = byp_valid_reg;
        byp_addr_next     = byp_addr_reg;
        byp_word_next     = byp_word_reg;
        ram_we    = 1'b0;
        ram_waddr = cur_corner;
        ram_wdata = new_word;
        ram_re    = 1'b0;
        ram_raddr = head_job.corner[0];
        pop       = 1'b0;
        emit      = 1'b0;
        emit_kind = tfic_pkg::KIND_MAP;
        emit_last = 1'b0;
        emit_data = {48'd0, new_compact, cur_corner};
        job_done  = 1'b0;
        do_end    = 1'b0;
        take_head = 1'b0;

        case (state_reg)
            ST_CLEAR: begin
                ram_we          = 1'b1;
                ram_waddr       = clear_addr_reg;
                ram_wdata       = {tfic_pkg::EPOCH_INVALID, tfic_pkg::INDEX_W'(0)};
                clear_addr_next = clear_addr_reg + tfic_pkg::INDEX_W'(1);
                byp_valid_next  = 1'b0;
                if (clear_addr_reg == {tfic_pkg::INDEX_W{1'b1}}) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (!q_status.empty) begin
                    pop = 1'b1;
                    if (head_job.keep) begin
                        take_head = 1'b1;
                    end else begin
                        do_end = 1'b1;
                    end
                end
            end
            ST_D0, ST_D1, ST_D2: begin
                if (out_free) begin
                    if (!hit) begin
                        ram_we            = 1'b1;
                        next_compact_next = next_compact_reg + tfic_pkg::COMPACT_W'(1);
                        byp_valid_next    = 1'b1;
                        byp_addr_next     = cur_corner;
                        byp_word_next     = new_word;
                        emit              = 1'b1;
                    end
                    case (state_reg)
                        ST_D0: begin
                            mapped0_next = mapped_cur;
                            ram_re       = 1'b1;
                            ram_raddr    = job_reg.corner[1];
                            state_next   = ST_D1;
                        end
                        ST_D1: begin
                            mapped1_next = mapped_cur;
                            ram_re       = 1'b1;
                            ram_raddr    = job_reg.corner[2];
                            state_next   = ST_D2;
                        end
                        default: begin
                            mapped2_next = mapped_cur;
                            if (!hit) begin
                                state_next = ST_TRI;
                            end else begin
                                // no new vertex: triangle goes out right away
                                emit      = 1'b1;
                                emit_kind = tfic_pkg::KIND_TRI;
                                emit_last = 1'b1;
                                emit_data = tri_data(mapped0_reg, mapped1_reg, mapped_cur,
                                                     job_reg.swap);
                                job_done  = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_TRI: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_kind = tfic_pkg::KIND_TRI;
                    emit_last = 1'b1;
                    emit_data = tri_data(mapped0_reg, mapped1_reg, mapped2_reg, job_reg.swap);
                    job_done  = 1'b1;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase

        if (job_done) begin
            state_next = ST_IDLE;
            if (job_reg.stream_end) begin
                do_end = 1'b1;
            end else if (!q_status.empty && head_job.keep) begin
                pop       = 1'b1;
                take_head = 1'b1;
            end
        end

        if (take_head) begin
            job_next   = head_job;
            ram_re     = 1'b1;
            ram_raddr  = head_job.corner[0];
            state_next = ST_D0;
        end

        // stream end: new epoch, or a full clearing sweep once epochs run out
        if (do_end) begin
            next_compact_next = '0;
            if (epoch_reg == tfic_pkg::EPOCH_LAST) begin
                epoch_next      = '0;
                clear_addr_next = '0;
                state_next      = ST_CLEAR;
            end else begin
                epoch_next = epoch_reg + tfic_pkg::EPOCH_W'(1);
                state_next = ST_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        job_reg      <= job_next;
        mapped0_reg  <= mapped0_next;
        mapped1_reg  <= mapped1_next;
        mapped2_reg  <= mapped2_next;
        byp_addr_reg <= byp_addr_next;
        byp_word_reg <= byp_word_next;
        if (out_free && emit) begin
            m_kind_reg <= emit_kind;
            m_data_reg <= emit_data;
            m_last_reg <= emit_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_CLEAR;
            epoch_reg        <= '0;
            next_compact_reg <= '0;
            clear_addr_reg   <= '0;
            byp_valid_reg    <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            epoch_reg        <= epoch_next;
            next_compact_reg <= next_compact_next;
            clear_addr_reg   <= clear_addr_next;
            byp_valid_reg    <= byp_valid_next;
            if (out_free) begin
                m_valid_reg <= emit;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_kind  = m_kind_reg;
    assign m_data  = m_data_reg;
    assign m_last  = m_last_reg;

endmodule
